FILE: rtl/core/rational_arithmetic_unit_core_defines.svh
// Assertion macros shared by the checker of the rational arithmetic unit.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
// Used by every module under rtl/core; no dependencies.
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int IN_W = 32;
  localparam int WIDE = 64;
  localparam int DEN_W = 63;

  localparam logic [3:0] OP_BUILD = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_NEG = 4'd5;
  localparam logic [3:0] OP_INV = 4'd6;
  localparam logic [3:0] OP_LT = 4'd7;
  localparam logic [3:0] OP_LE = 4'd8;
  localparam logic [3:0] OP_GT = 4'd9;
  localparam logic [3:0] OP_GE = 4'd10;
  localparam logic [3:0] OP_EQ = 4'd11;
  localparam logic [3:0] OP_NE = 4'd12;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_COPY, CMD_MUL, CMD_DIV, CMD_GCD, CMD_COMBINE,
    CMD_OUT_VAL, CMD_OUT_ZERO, CMD_OUT_ERR, CMD_OUT_CMP
  } cmd_kind_t;

  typedef enum logic [3:0] {
    SRC_AN, SRC_AD, SRC_BN, SRC_BD, SRC_NUM, SRC_DEN, SRC_X, SRC_Y, SRC_G
  } src_t;

  typedef enum logic [2:0] {DST_NUM, DST_DEN, DST_X, DST_Y, DST_G} dst_t;

  typedef enum logic [2:0] {
    SGN_KEEP, SGN_XOR_AB, SGN_A, SGN_NOT_A, SGN_A_XOR_AD
  } sgn_t;

  typedef struct packed {
    cmd_kind_t kind;
    src_t      src_a;
    src_t      src_b;
    dst_t      dst;
    sgn_t      sgn;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic       num_zero;
    logic [3:0] op;
    logic       an_zero;
    logic       ad_bad;
    logic       ad_zero;
    logic       bd_bad;
    logic       bn_zero;
  } status_t;

endpackage

FILE: rtl/core/rau_div.sv
// Restoring divider, one quotient bit per cycle, quotient only.
// Depends on rau_pkg for the word width.
module rau_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rau_pkg::WIDE-1:0]  dividend,
  input  logic [rau_pkg::WIDE-1:0]  divisor,
  output logic                      busy,
  output logic                      done,
  output logic [rau_pkg::WIDE-1:0]  quotient
);

  localparam int W = rau_pkg::WIDE;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  assign shifted = {rem, quotient[W-1]};
  assign diff = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dvs <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[W+1]) begin
          rem <= diff[W-1:0];
          quotient <= {quotient[W-2:0], 1'b1};
        end else begin
          rem <= shifted[W-1:0];
          quotient <= {quotient[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/rau_gcd.sv
// Binary gcd of two nonzero words, one reduction step per cycle.
// Depends on rau_pkg for the word width.
module rau_gcd (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rau_pkg::WIDE-1:0]  u_in,
  input  logic [rau_pkg::WIDE-1:0]  v_in,
  output logic                      busy,
  output logic                      done,
  output logic [rau_pkg::WIDE-1:0]  g
);

  localparam int W = rau_pkg::WIDE;
  localparam int KW = $clog2(W);

  logic [W-1:0]  u;
  logic [W-1:0]  v;
  logic [KW-1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        u <= u_in;
        v <= v_in;
        k <= '0;
      end else if (busy) begin
        if (u == v) begin
          g <= u << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u > v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
    end
  end

endmodule

FILE: rtl/core/rau_dp.sv
// Datapath: operand registers, shift-add multiplier, divider and gcd units,
// sign combine and the result register. Depends on rau_pkg, rau_div, rau_gcd.
module rau_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rau_pkg::cmd_t                 cmd,
  output rau_pkg::status_t              status,
  input  logic [3:0]                    op,
  input  logic signed [rau_pkg::IN_W-1:0] a_num,
  input  logic signed [rau_pkg::IN_W-1:0] a_den,
  input  logic signed [rau_pkg::IN_W-1:0] b_num,
  input  logic signed [rau_pkg::IN_W-1:0] b_den,
  output logic signed [rau_pkg::WIDE-1:0] res_num,
  output logic [rau_pkg::DEN_W-1:0]       res_den,
  output logic                          truth,
  output logic                          error
);

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int W = rau_pkg::WIDE;
  localparam int MCW = $clog2(OW);
  localparam logic [MCW-1:0] MUL_LAST = MCW'(OW - 1);

  function automatic logic [OW:0] take(input logic [rau_pkg::IN_W-1:0] raw);
    logic [OW-1:0] v;
    v = raw[OW-1:0];
    take = {v[OW-1], v[OW-1] ? OW'(~v + 1'b1) : v};
  endfunction

  logic [3:0]    op_r;
  logic          an_neg, ad_neg, bn_neg, bd_neg;
  logic [OW-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic [W-1:0]  num, den, xr, yr, gr;
  logic          neg;
  rau_pkg::dst_t dst_r;

  logic [W-1:0] a_val, b_val;

  logic          mul_busy, mul_done;
  logic [MCW-1:0] mul_cnt;
  logic [OW-1:0] mul_mcand;
  logic [W-1:0]  mul_prod;
  logic [OW:0]   mul_sum;

  logic         div_busy, div_done, gcd_busy, gcd_done;
  logic [W-1:0] div_q, gcd_g;

  logic         wr_en;
  rau_pkg::dst_t wr_dst;
  logic [W-1:0] wr_val;

  logic         pn, qn, num_zero;
  logic [W-1:0] cnum;
  logic         cneg;
  logic         sgn_val;
  logic         tr;

  function automatic logic [W-1:0] pick(input rau_pkg::src_t s, input logic [OW-1:0] an,
                                        input logic [OW-1:0] ad, input logic [OW-1:0] bn,
                                        input logic [OW-1:0] bd, input logic [W-1:0] n,
                                        input logic [W-1:0] d, input logic [W-1:0] x,
                                        input logic [W-1:0] y, input logic [W-1:0] gg);
    unique case (s)
      rau_pkg::SRC_AN:  pick = W'(an);
      rau_pkg::SRC_AD:  pick = W'(ad);
      rau_pkg::SRC_BN:  pick = W'(bn);
      rau_pkg::SRC_BD:  pick = W'(bd);
      rau_pkg::SRC_NUM: pick = n;
      rau_pkg::SRC_DEN: pick = d;
      rau_pkg::SRC_X:   pick = x;
      rau_pkg::SRC_Y:   pick = y;
      rau_pkg::SRC_G:   pick = gg;
      default:          pick = '0;
    endcase
  endfunction

  assign a_val = pick(cmd.src_a, an_mag, ad_mag, bn_mag, bd_mag, num, den, xr, yr, gr);
  assign b_val = pick(cmd.src_b, an_mag, ad_mag, bn_mag, bd_mag, num, den, xr, yr, gr);

  assign num_zero = (num == '0);
  assign status = '{busy: mul_busy | mul_done | div_busy | div_done | gcd_busy | gcd_done,
                    num_zero: num_zero, op: op_r, an_zero: an_mag == '0,
                    ad_bad: ad_neg | (ad_mag == '0), ad_zero: ad_mag == '0,
                    bd_bad: bd_neg | (bd_mag == '0), bn_zero: bn_mag == '0};

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.kind == rau_pkg::CMD_DIV),
    .dividend (a_val),
    .divisor  (b_val),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.kind == rau_pkg::CMD_GCD),
    .u_in  (a_val),
    .v_in  (b_val),
    .busy  (gcd_busy),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  assign mul_sum = {1'b0, mul_prod[W-1:OW]} + (mul_prod[0] ? {1'b0, mul_mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.kind == rau_pkg::CMD_MUL) begin
        mul_busy <= 1'b1;
        mul_cnt <= '0;
        mul_mcand <= a_val[OW-1:0];
        mul_prod <= {{(W-OW){1'b0}}, b_val[OW-1:0]};
      end else if (mul_busy) begin
        mul_prod <= {mul_sum, mul_prod[OW-1:1]};
        mul_cnt <= mul_cnt + 1'b1;
        if (mul_cnt == MUL_LAST) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    pn = an_neg;
    qn = bn_neg ^ (op_r != rau_pkg::OP_ADD);
    if (pn == qn) begin
      cnum = num + yr;
      cneg = pn;
    end else if (num >= yr) begin
      cnum = num - yr;
      cneg = pn;
    end else begin
      cnum = yr - num;
      cneg = qn;
    end
    if (cnum == '0) begin
      cneg = 1'b0;
    end
  end

  always_comb begin
    unique case (cmd.sgn)
      rau_pkg::SGN_XOR_AB:   sgn_val = an_neg ^ bn_neg;
      rau_pkg::SGN_A:        sgn_val = an_neg;
      rau_pkg::SGN_NOT_A:    sgn_val = !an_neg;
      rau_pkg::SGN_A_XOR_AD: sgn_val = an_neg ^ ad_neg;
      default:               sgn_val = neg;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_dst = dst_r;
    wr_val = mul_prod;
    if (cmd.kind == rau_pkg::CMD_COPY) begin
      wr_en = 1'b1;
      wr_dst = cmd.dst;
      wr_val = a_val;
    end else if (mul_done) begin
      wr_en = 1'b1;
    end else if (div_done) begin
      wr_en = 1'b1;
      wr_val = div_q;
    end else if (gcd_done) begin
      wr_en = 1'b1;
      wr_val = gcd_g;
    end
  end

  always_comb begin
    unique case (op_r)
      rau_pkg::OP_LT: tr = neg;
      rau_pkg::OP_LE: tr = neg || num_zero;
      rau_pkg::OP_GT: tr = !neg && !num_zero;
      rau_pkg::OP_GE: tr = !neg;
      rau_pkg::OP_EQ: tr = num_zero;
      rau_pkg::OP_NE: tr = !num_zero;
      default:        tr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.kind == rau_pkg::CMD_LOAD) begin
      op_r <= op;
      {an_neg, an_mag} <= take(a_num);
      {ad_neg, ad_mag} <= take(a_den);
      {bn_neg, bn_mag} <= take(b_num);
      {bd_neg, bd_mag} <= take(b_den);
    end
    if (cmd.kind == rau_pkg::CMD_MUL || cmd.kind == rau_pkg::CMD_DIV ||
        cmd.kind == rau_pkg::CMD_GCD) begin
      dst_r <= cmd.dst;
    end
    if (cmd.sgn != rau_pkg::SGN_KEEP) begin
      neg <= sgn_val;
    end
    if (cmd.kind == rau_pkg::CMD_COMBINE) begin
      num <= cnum;
      neg <= cneg;
    end
    if (wr_en) begin
      unique case (wr_dst)
        rau_pkg::DST_NUM: num <= wr_val;
        rau_pkg::DST_DEN: den <= wr_val;
        rau_pkg::DST_X:   xr <= wr_val;
        rau_pkg::DST_Y:   yr <= wr_val;
        default:          gr <= wr_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      rau_pkg::CMD_OUT_VAL: begin
        res_num <= neg ? W'(~num + 1'b1) : num;
        res_den <= den[rau_pkg::DEN_W-1:0];
        truth <= 1'b0;
        error <= 1'b0;
      end
      rau_pkg::CMD_OUT_ZERO: begin
        res_num <= '0;
        res_den <= rau_pkg::DEN_W'(1);
        truth <= 1'b0;
        error <= 1'b0;
      end
      rau_pkg::CMD_OUT_ERR: begin
        res_num <= W'(1);
        res_den <= rau_pkg::DEN_W'(1);
        truth <= 1'b0;
        error <= 1'b1;
      end
      rau_pkg::CMD_OUT_CMP: begin
        res_num <= '0;
        res_den <= '0;
        truth <= tr;
        error <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/rau_ctrl.sv
// Controller: sequences datapath commands for each operation and owns the
// handshakes. Depends on rau_pkg.
module rau_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rau_pkg::status_t status,
  output rau_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_REDUCE, S_OUT} state_t;

  state_t             state;
  logic [2:0]         idx;
  logic               red;
  rau_pkg::cmd_kind_t outk;

  rau_pkg::cmd_t step;
  logic          last;
  logic          err;
  logic          slot_free;
  logic          binary_op;

  function automatic rau_pkg::cmd_t mk(input rau_pkg::cmd_kind_t k, input rau_pkg::src_t a,
                                       input rau_pkg::src_t b, input rau_pkg::dst_t d,
                                       input rau_pkg::sgn_t s);
    mk = '{kind: k, src_a: a, src_b: b, dst: d, sgn: s};
  endfunction

  always_comb begin
    step = mk(rau_pkg::CMD_NONE, rau_pkg::SRC_AN, rau_pkg::SRC_AN, rau_pkg::DST_NUM,
              rau_pkg::SGN_KEEP);
    last = 1'b0;
    if (red) begin
      unique case (idx)
        3'd0: step = mk(rau_pkg::CMD_GCD, rau_pkg::SRC_NUM, rau_pkg::SRC_DEN,
                        rau_pkg::DST_G, rau_pkg::SGN_KEEP);
        3'd1: step = mk(rau_pkg::CMD_DIV, rau_pkg::SRC_NUM, rau_pkg::SRC_G,
                        rau_pkg::DST_NUM, rau_pkg::SGN_KEEP);
        default: begin
          step = mk(rau_pkg::CMD_DIV, rau_pkg::SRC_DEN, rau_pkg::SRC_G,
                    rau_pkg::DST_DEN, rau_pkg::SGN_KEEP);
          last = 1'b1;
        end
      endcase
    end else begin
      unique case (status.op)
        rau_pkg::OP_BUILD: begin
          last = (idx != 3'd0);
          step = last ? mk(rau_pkg::CMD_COPY, rau_pkg::SRC_AD, rau_pkg::SRC_AD,
                           rau_pkg::DST_DEN, rau_pkg::SGN_KEEP)
                      : mk(rau_pkg::CMD_COPY, rau_pkg::SRC_AN, rau_pkg::SRC_AN,
                           rau_pkg::DST_NUM, rau_pkg::SGN_A_XOR_AD);
        end
        rau_pkg::OP_MUL: begin
          last = (idx != 3'd0);
          step = last ? mk(rau_pkg::CMD_MUL, rau_pkg::SRC_AD, rau_pkg::SRC_BD,
                           rau_pkg::DST_DEN, rau_pkg::SGN_KEEP)
                      : mk(rau_pkg::CMD_MUL, rau_pkg::SRC_AN, rau_pkg::SRC_BN,
                           rau_pkg::DST_NUM, rau_pkg::SGN_XOR_AB);
        end
        rau_pkg::OP_DIV: begin
          last = (idx != 3'd0);
          step = last ? mk(rau_pkg::CMD_MUL, rau_pkg::SRC_AD, rau_pkg::SRC_BN,
                           rau_pkg::DST_DEN, rau_pkg::SGN_KEEP)
                      : mk(rau_pkg::CMD_MUL, rau_pkg::SRC_AN, rau_pkg::SRC_BD,
                           rau_pkg::DST_NUM, rau_pkg::SGN_XOR_AB);
        end
        rau_pkg::OP_NEG: begin
          last = (idx != 3'd0);
          step = last ? mk(rau_pkg::CMD_COPY, rau_pkg::SRC_AD, rau_pkg::SRC_AD,
                           rau_pkg::DST_DEN, rau_pkg::SGN_KEEP)
                      : mk(rau_pkg::CMD_COPY, rau_pkg::SRC_AN, rau_pkg::SRC_AN,
                           rau_pkg::DST_NUM, rau_pkg::SGN_NOT_A);
        end
        rau_pkg::OP_INV: begin
          last = (idx != 3'd0);
          step = last ? mk(rau_pkg::CMD_COPY, rau_pkg::SRC_AN, rau_pkg::SRC_AN,
                           rau_pkg::DST_DEN, rau_pkg::SGN_KEEP)
                      : mk(rau_pkg::CMD_COPY, rau_pkg::SRC_AD, rau_pkg::SRC_AD,
                           rau_pkg::DST_NUM, rau_pkg::SGN_A);
        end
        default: begin
          // Sum or difference over the lcm: x = ad/g, y = bd/g, den = x*bd.
          unique case (idx)
            3'd0: step = mk(rau_pkg::CMD_GCD, rau_pkg::SRC_AD, rau_pkg::SRC_BD,
                            rau_pkg::DST_G, rau_pkg::SGN_KEEP);
            3'd1: step = mk(rau_pkg::CMD_DIV, rau_pkg::SRC_AD, rau_pkg::SRC_G,
                            rau_pkg::DST_X, rau_pkg::SGN_KEEP);
            3'd2: step = mk(rau_pkg::CMD_DIV, rau_pkg::SRC_BD, rau_pkg::SRC_G,
                            rau_pkg::DST_Y, rau_pkg::SGN_KEEP);
            3'd3: step = mk(rau_pkg::CMD_MUL, rau_pkg::SRC_X, rau_pkg::SRC_BD,
                            rau_pkg::DST_DEN, rau_pkg::SGN_KEEP);
            3'd4: step = mk(rau_pkg::CMD_MUL, rau_pkg::SRC_AN, rau_pkg::SRC_Y,
                            rau_pkg::DST_NUM, rau_pkg::SGN_KEEP);
            3'd5: step = mk(rau_pkg::CMD_MUL, rau_pkg::SRC_BN, rau_pkg::SRC_X,
                            rau_pkg::DST_Y, rau_pkg::SGN_KEEP);
            default: begin
              step = mk(rau_pkg::CMD_COMBINE, rau_pkg::SRC_NUM, rau_pkg::SRC_Y,
                        rau_pkg::DST_NUM, rau_pkg::SGN_KEEP);
              last = 1'b1;
            end
          endcase
        end
      endcase
    end
  end

  assign binary_op = (status.op <= rau_pkg::OP_DIV) || (status.op >= rau_pkg::OP_LT);
  assign err = (status.op == rau_pkg::OP_BUILD) ? status.ad_zero
             : (status.op > rau_pkg::OP_NE) || status.ad_bad || (binary_op && status.bd_bad) ||
               (status.op == rau_pkg::OP_DIV && status.bn_zero) ||
               (status.op == rau_pkg::OP_INV && status.an_zero);
  assign slot_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = mk(rau_pkg::CMD_NONE, rau_pkg::SRC_AN, rau_pkg::SRC_AN, rau_pkg::DST_NUM,
             rau_pkg::SGN_KEEP);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.kind = rau_pkg::CMD_LOAD;
        end
      end
      S_ISSUE: cmd = step;
      S_OUT: begin
        if (slot_free) begin
          cmd.kind = outk;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
      red <= 1'b0;
      outk <= rau_pkg::CMD_OUT_ERR;
    end else begin
      if (state == S_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= '0;
          red <= 1'b0;
          if (err) begin
            outk <= rau_pkg::CMD_OUT_ERR;
            state <= S_OUT;
          end else begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (!status.busy) begin
            if (!last) begin
              idx <= idx + 1'b1;
              state <= S_ISSUE;
            end else if (red) begin
              outk <= rau_pkg::CMD_OUT_VAL;
              state <= S_OUT;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (status.op >= rau_pkg::OP_LT) begin
            outk <= rau_pkg::CMD_OUT_CMP;
            state <= S_OUT;
          end else if (status.num_zero) begin
            outk <= rau_pkg::CMD_OUT_ZERO;
            state <= S_OUT;
          end else begin
            idx <= '0;
            red <= 1'b1;
            state <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/rational_arithmetic_unit_core.sv
// Exact fraction unit: a controller sequencing a shared multiplier, divider
// and gcd datapath. Depends on rau_pkg, rau_ctrl and rau_dp.
//
// The input channel (in_valid/in_ready) carries one request: an operation
// code and two fractions a_num/a_den and b_num/b_den. The output channel
// (out_valid/out_ready) returns one result per request: a reduced fraction
// res_num/res_den with the sign on the numerator, a comparison bit truth,
// and error for a zero denominator, or a negative one outside build, in an
// operand that is used, division by zero, inverting zero or an undefined
// operation code. One request is worked at a time; an error skips the
// datapath steps. The datapath has a 64-bit restoring divider, a 32-bit
// shift-add multiplier and a binary gcd. Add and subtract run a gcd of the
// denominators, two divides, three multiplies and a combine, as do
// comparisons; multiply and divide run two multiplies, build, negate and
// invert two copies. Except for comparisons, a nonzero result is then
// reduced with a gcd and two divides. A finished result sits in the output
// register; the next request is accepted while it waits, and the block
// stalls at its own output if the receiver has still not taken the previous
// one. Reset clears out_valid and returns the controller to idle.
module rational_arithmetic_unit_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3:0]                      op,
  input  logic signed [rau_pkg::IN_W-1:0] a_num,
  input  logic signed [rau_pkg::IN_W-1:0] a_den,
  input  logic signed [rau_pkg::IN_W-1:0] b_num,
  input  logic signed [rau_pkg::IN_W-1:0] b_den,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [rau_pkg::WIDE-1:0] res_num,
  output logic [rau_pkg::DEN_W-1:0]       res_den,
  output logic                            truth,
  output logic                            error
);

  rau_pkg::cmd_t    cmd;
  rau_pkg::status_t status;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rau_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .op      (op),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .res_num (res_num),
    .res_den (res_den),
    .truth   (truth),
    .error   (error)
  );

endmodule

FILE: rtl/core/rau_checker.sv
// Port-level checks on the rational arithmetic unit, bound to the top level.
// Depends on rational_arithmetic_unit_core_defines.svh and rau_pkg.
`include "rational_arithmetic_unit_core_defines.svh"

module rau_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [rau_pkg::WIDE-1:0] res_num,
  input logic [rau_pkg::DEN_W-1:0]       res_den,
  input logic                            truth,
  input logic                            error
);

  `RAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_num) && $stable(res_den), "stalled result changed")
  `RAU_ASSERT_NOW(a_err_shape, out_valid && error, res_num == 1 && res_den == 1 && !truth, "error result is not 1/1")
  `RAU_ASSERT_NOW(a_truth_shape, out_valid && truth, res_num == 0 && res_den == 0 && !error, "comparison result carries a fraction")
  `RAU_ASSERT_NOW(a_den_zero, out_valid && res_den == 0, res_num == 0 && !error, "zero denominator outside a comparison")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
